// File: rtl/cgpg_pkg.sv
`default_nettype none

package cgpg_pkg;

    // Frame size
    localparam int ROWS = 1024;
    localparam int COLS = 768;

    // Position width: wide enough for either size, and never under the 10-bit index fields
    localparam int MAXD   = (ROWS > COLS) ? ROWS : COLS;
    localparam int T_W    = ($clog2(MAXD + 1) > 10) ? $clog2(MAXD + 1) : 10;
    localparam int IDX_W  = 10;

    // Blend numerator a*(n-t) + b*t stays below 256*n
    localparam int NUM_W  = 8 + T_W;

    // Constant division: multiply by ceil(2^DIV_SH / n), then one correction step
    localparam int DIV_SH = 30;
    localparam int PROD_W = NUM_W + DIV_SH;

    localparam logic [T_W-1:0]    ROWS_T    = T_W'(ROWS);
    localparam logic [T_W-1:0]    COLS_T    = T_W'(COLS);
    localparam logic [T_W-1:0]    ROW_LAST  = T_W'(ROWS - 1);
    localparam logic [T_W-1:0]    COL_LAST  = T_W'(COLS - 1);
    localparam logic [DIV_SH-1:0] ROW_RECIP = DIV_SH'((2**DIV_SH + ROWS - 1) / ROWS);
    localparam logic [DIV_SH-1:0] COL_RECIP = DIV_SH'((2**DIV_SH + COLS - 1) / COLS);

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Stream data widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        CFG_TOP_LEFT     = 2'd0,
        CFG_TOP_RIGHT    = 2'd1,
        CFG_BOTTOM_LEFT  = 2'd2,
        CFG_BOTTOM_RIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [T_W-1:0] row;
        logic [T_W-1:0] col;
        logic           first;      // column 0: latch new edge colors
        logic           col_last;   // last column: pixel is the right edge
        logic           frame_end;
    } t_pix_meta;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // channel 0 = red (23:16), 1 = green, 2 = blue
    function automatic logic [7:0] get_chan(logic [23:0] rgb, int c);
        return rgb[(2 - c) * 8 +: 8];
    endfunction

    // a*(n-t) + b*t
    function automatic logic [NUM_W-1:0] blend_num(logic [7:0] a, logic [7:0] b,
                                                  logic [T_W-1:0] t, logic [T_W-1:0] n);
        return NUM_W'(a) * NUM_W'(n - t) + NUM_W'(b) * NUM_W'(t);
    endfunction

    // Estimate from the reciprocal product is exact or one high; fix it up
    function automatic logic [7:0] quot_fix(logic [PROD_W-1:0] prod,
                                           logic [NUM_W-1:0] num, logic [T_W-1:0] d);
        logic [8:0]       qe;
        logic [NUM_W-1:0] back;
        qe   = prod[DIV_SH +: 9];
        back = NUM_W'(qe) * NUM_W'(d);
        if (back > num) begin
            qe = qe - 9'd1;
        end
        return qe[7:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/cgpg_front.sv
`default_nettype none

// Position counters; tags each word with its row/column and pushes it to the queue
module cgpg_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_restart,
    input  wire logic                  i_full,
    output logic                       o_push,
    output cgpg_pkg::t_pix_meta        o_meta
);

    logic [cgpg_pkg::T_W-1:0] r_row, n_row;
    logic [cgpg_pkg::T_W-1:0] r_col, n_col;
    logic [cgpg_pkg::T_W-1:0] w_row, w_col;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_row = i_restart ? '0 : r_row;
        w_col = i_restart ? '0 : r_col;

        o_meta.row       = w_row;
        o_meta.col       = w_col;
        o_meta.first     = (w_col == '0);
        o_meta.col_last  = (w_col == cgpg_pkg::COL_LAST);
        o_meta.frame_end = (w_col == cgpg_pkg::COL_LAST) && (w_row == cgpg_pkg::ROW_LAST);

        n_row = w_row;
        n_col = w_col + 1'b1;
        if (w_col >= cgpg_pkg::COL_LAST) begin
            n_col = '0;
            n_row = (w_row >= cgpg_pkg::ROW_LAST) ? '0 : w_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cgpg_fifo.sv
`default_nettype none

// Small queue of tagged words between front and back
module cgpg_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire cgpg_pkg::t_pix_meta   i_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output cgpg_pkg::t_pix_meta        o_data,
    output logic                       o_empty
);

    cgpg_pkg::t_pix_meta         r_mem [cgpg_pkg::QDEPTH];
    logic [cgpg_pkg::QAW-1:0]    r_wr, r_rd;
    logic [cgpg_pkg::QAW:0]      r_cnt;
    logic                        w_do_pop;

    assign o_full   = (r_cnt == (cgpg_pkg::QAW + 1)'(cgpg_pkg::QDEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_data   = r_mem[r_rd];
    assign w_do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cgpg_back.sv
`default_nettype none

// Interpolation pipeline: row blend -> edge latch -> column blend -> output register
module cgpg_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [23:0]           i_top_left,
    input  wire logic [23:0]           i_top_right,
    input  wire logic [23:0]           i_bottom_left,
    input  wire logic [23:0]           i_bottom_right,
    input  wire logic                  i_empty,
    input  wire cgpg_pkg::t_pix_meta   i_meta,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output cgpg_pkg::t_pixel           o_pixel,
    output cgpg_pkg::t_pix_meta        o_meta
);

    localparam int NW = cgpg_pkg::NUM_W;
    localparam int PW = cgpg_pkg::PROD_W;

    logic w_en;

    // stage 1: row numerators (0..2 left edge, 3..5 right edge)
    logic                  r_s1_vld;
    cgpg_pkg::t_pix_meta   r_s1_meta;
    logic [NW-1:0]         r_s1_num [6];
    // stage 2: reciprocal products
    logic                  r_s2_vld;
    cgpg_pkg::t_pix_meta   r_s2_meta;
    logic [NW-1:0]         r_s2_num [6];
    logic [PW-1:0]         r_s2_prod [6];
    // stage 3: edge colors of the current row
    logic                  r_s3_vld;
    cgpg_pkg::t_pix_meta   r_s3_meta;
    logic [7:0]            r_left [3];
    logic [7:0]            r_right [3];
    // stage 4: column numerators
    logic                  r_s4_vld;
    cgpg_pkg::t_pix_meta   r_s4_meta;
    logic [NW-1:0]         r_s4_num [3];
    logic [7:0]            r_s4_left [3];
    logic [7:0]            r_s4_right [3];
    // stage 5: column products
    logic                  r_s5_vld;
    cgpg_pkg::t_pix_meta   r_s5_meta;
    logic [NW-1:0]         r_s5_num [3];
    logic [PW-1:0]         r_s5_prod [3];
    logic [7:0]            r_s5_left [3];
    logic [7:0]            r_s5_right [3];
    // output register
    logic                  r_out_vld;
    cgpg_pkg::t_pix_meta   r_out_meta;
    logic [7:0]            r_out_pix [3];

    assign w_en    = !r_out_vld || i_ready;
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_out_vld;
    assign o_meta  = r_out_meta;
    assign o_pixel.red   = r_out_pix[0];
    assign o_pixel.green = r_out_pix[1];
    assign o_pixel.blue  = r_out_pix[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_left[c]  <= '0;
                r_right[c] <= '0;
            end
        end else if (w_en) begin
            r_s1_vld  <= !i_empty;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_out_vld <= r_s5_vld;
            // edges latch as a column-0 word enters stage 3
            if (r_s2_vld && r_s2_meta.first) begin
                for (int c = 0; c < 3; c++) begin
                    r_left[c]  <= cgpg_pkg::quot_fix(r_s2_prod[c], r_s2_num[c],
                                                     cgpg_pkg::ROWS_T);
                    r_right[c] <= cgpg_pkg::quot_fix(r_s2_prod[c+3], r_s2_num[c+3],
                                                     cgpg_pkg::ROWS_T);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_meta <= i_meta;
            for (int c = 0; c < 3; c++) begin
                r_s1_num[c]   <= cgpg_pkg::blend_num(cgpg_pkg::get_chan(i_bottom_left, c),
                                                     cgpg_pkg::get_chan(i_top_left, c),
                                                     i_meta.row, cgpg_pkg::ROWS_T);
                r_s1_num[c+3] <= cgpg_pkg::blend_num(cgpg_pkg::get_chan(i_bottom_right, c),
                                                     cgpg_pkg::get_chan(i_top_right, c),
                                                     i_meta.row, cgpg_pkg::ROWS_T);
            end

            r_s2_meta <= r_s1_meta;
            for (int k = 0; k < 6; k++) begin
                r_s2_num[k]  <= r_s1_num[k];
                r_s2_prod[k] <= PW'(r_s1_num[k]) * PW'(cgpg_pkg::ROW_RECIP);
            end

            r_s3_meta <= r_s2_meta;

            r_s4_meta <= r_s3_meta;
            for (int c = 0; c < 3; c++) begin
                r_s4_num[c]   <= cgpg_pkg::blend_num(r_left[c], r_right[c],
                                                     r_s3_meta.col, cgpg_pkg::COLS_T);
                r_s4_left[c]  <= r_left[c];
                r_s4_right[c] <= r_right[c];
            end

            r_s5_meta <= r_s4_meta;
            for (int c = 0; c < 3; c++) begin
                r_s5_num[c]   <= r_s4_num[c];
                r_s5_prod[c]  <= PW'(r_s4_num[c]) * PW'(cgpg_pkg::COL_RECIP);
                r_s5_left[c]  <= r_s4_left[c];
                r_s5_right[c] <= r_s4_right[c];
            end

            r_out_meta <= r_s5_meta;
            for (int c = 0; c < 3; c++) begin
                if (r_s5_meta.first) begin
                    r_out_pix[c] <= r_s5_left[c];
                end else if (r_s5_meta.col_last) begin
                    r_out_pix[c] <= r_s5_right[c];
                end else begin
                    r_out_pix[c] <= cgpg_pkg::quot_fix(r_s5_prod[c], r_s5_num[c],
                                                       cgpg_pkg::COLS_T);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/corner_gradient_pixel_generator.sv
// Path: a word accepted on s_axis goes through the queue, 5 pipe stages and the output register to m_axis.
// Throughput: one pixel per clock; the interpolation pipeline advances whenever its output
// register is empty or being taken, and a 4-word queue lets the input run on while it stalls.
// Reset: i_rst_n is synchronous, active low; it clears the corner registers, the position
// counters, the queue, all pipeline valid bits and the latched edge colors.
`default_nettype none

module corner_gradient_pixel_generator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input words
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [cgpg_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [0] restart, [7:1] zero
    // output words
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [33:24] row_index, [43:34] column_index,
    // [47:44] zero
    output logic [cgpg_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tlast,  // frame_end
    // corner color writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [23:0]                       i_cfg_data
);

    // Corner colors, red 23:16, green 15:8, blue 7:0
    logic [23:0]          r_top_left, r_top_right, r_bottom_left, r_bottom_right;

    logic                 w_push, w_full, w_pop, w_empty;
    cgpg_pkg::t_pix_meta  w_push_meta, w_pop_meta, w_out_meta;
    cgpg_pkg::t_pixel     w_out_pix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_left     <= '0;
            r_top_right    <= '0;
            r_bottom_left  <= '0;
            r_bottom_right <= '0;
        end else if (i_cfg_valid) begin
            case (cgpg_pkg::t_cfg_idx'(i_cfg_index))
                cgpg_pkg::CFG_TOP_LEFT:     r_top_left     <= i_cfg_data;
                cgpg_pkg::CFG_TOP_RIGHT:    r_top_right    <= i_cfg_data;
                cgpg_pkg::CFG_BOTTOM_LEFT:  r_bottom_left  <= i_cfg_data;
                cgpg_pkg::CFG_BOTTOM_RIGHT: r_bottom_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: counts position, handles restart, tags each word
    cgpg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_restart (s_axis_tdata[0]),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_meta    (w_push_meta)
    );

    // Queue decouples the counters from the interpolation pipe
    cgpg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_meta),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_meta),
        .o_empty (w_empty)
    );

    // Back: row blend, edge latch at column 0, column blend, output register
    cgpg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_top_left     (r_top_left),
        .i_top_right    (r_top_right),
        .i_bottom_left  (r_bottom_left),
        .i_bottom_right (r_bottom_right),
        .i_empty        (w_empty),
        .i_meta         (w_pop_meta),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_pixel        (w_out_pix),
        .o_meta         (w_out_meta)
    );

    assign m_axis_tdata = {4'b0000,
                           w_out_meta.col[cgpg_pkg::IDX_W-1:0],
                           w_out_meta.row[cgpg_pkg::IDX_W-1:0],
                           w_out_pix.blue, w_out_pix.green, w_out_pix.red};
    assign m_axis_tlast = w_out_meta.frame_end;

    // frame end only ever marks the bottom-right pixel
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (w_out_meta.col == cgpg_pkg::COL_LAST && w_out_meta.row == cgpg_pkg::ROW_LAST))
        else $error("tlast on a pixel other than the frame's last");

    // a restart word enters the queue tagged as pixel 0
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) |->
            (w_push && w_push_meta.row == '0 && w_push_meta.col == '0 && w_push_meta.first))
        else $error("restart word not queued at row 0 column 0");

    // nothing leaves right after reset
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight out of reset");

endmodule

`default_nettype wire

// File: tb/tb_corner_gradient_pixel_generator.sv
`timescale 1ns / 100ps

module tb_corner_gradient_pixel_generator;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE       = 12;      // idle margin after the last result has come back
    localparam int STALL_LIMIT  = 2000;    // cycles with no word moving anywhere
    localparam int SHOWN_ERRORS = 10;
    localparam int ROW_PIXELS   = cgpg_pkg::COLS;

    // expected pixel word, fields as the block reports them
    typedef struct packed {
        logic [7:0]                 red;
        logic [7:0]                 green;
        logic [7:0]                 blue;
        logic [cgpg_pkg::IDX_W-1:0] row;
        logic [cgpg_pkg::IDX_W-1:0] col;
        logic                       frame_end;
    } t_pixel_word;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [cgpg_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [cgpg_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [1:0]                     i_cfg_index;
    logic [23:0]                    i_cfg_data;

    corner_gradient_pixel_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // gradient model state
    logic [23:0]      corner_rgb [4];
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      left_edge  [3];
    int unsigned      right_edge [3];

    t_pixel_word      expected_pixels [$];
    t_pixel_word      want_w;
    t_pixel_word      got_w;

    // idle control and bookkeeping
    bit               tx_idle_on;
    bit               rx_idle_on;
    int               mismatches;
    int               pixels_sent;
    int               pixels_checked;
    int               frame_ends_seen;
    int               restarts_sent;
    int               corner_writes;
    int               quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Gradient model
    // ---------------------------------------------------------------

    // channel 0 = red (23:16), 1 = green, 2 = blue
    function automatic int unsigned chan8(logic [23:0] rgb, int c);
        return int'(rgb >> (16 - 8 * c)) & 8'hFF;
    endfunction

    // exact floor of (a*(n-t) + b*t) / n
    function automatic int unsigned lerp_floor(int unsigned a, int unsigned b,
                                               int unsigned t, int unsigned n);
        return (a * (n - t) + b * t) / n;
    endfunction

    // produce the next pixel of the frame and step the position
    function automatic t_pixel_word next_pixel(bit restart);
        t_pixel_word w;
        int unsigned px [3];
        if (restart) begin
            row_pos = 0;
            col_pos = 0;
        end
        // edges are latched only in column 0, so corner writes mid-row wait a row
        if (col_pos == 0) begin
            for (int c = 0; c < 3; c++) begin
                left_edge[c]  = lerp_floor(chan8(corner_rgb[cgpg_pkg::CFG_BOTTOM_LEFT], c),
                                           chan8(corner_rgb[cgpg_pkg::CFG_TOP_LEFT], c),
                                           row_pos, cgpg_pkg::ROWS) & 8'hFF;
                right_edge[c] = lerp_floor(chan8(corner_rgb[cgpg_pkg::CFG_BOTTOM_RIGHT], c),
                                           chan8(corner_rgb[cgpg_pkg::CFG_TOP_RIGHT], c),
                                           row_pos, cgpg_pkg::ROWS) & 8'hFF;
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (col_pos == 0)
                px[c] = left_edge[c];
            else if (col_pos == cgpg_pkg::COLS - 1)
                px[c] = right_edge[c];
            else
                px[c] = lerp_floor(left_edge[c], right_edge[c], col_pos,
                                   cgpg_pkg::COLS) & 8'hFF;
        end
        w.red       = px[0][7:0];
        w.green     = px[1][7:0];
        w.blue      = px[2][7:0];
        w.row       = row_pos[cgpg_pkg::IDX_W-1:0];
        w.col       = col_pos[cgpg_pkg::IDX_W-1:0];
        w.frame_end = (row_pos == cgpg_pkg::ROWS - 1) && (col_pos == cgpg_pkg::COLS - 1);
        // step to the next row after the last column, and wrap to pixel 0 after the last pixel of the frame
        if (col_pos >= cgpg_pkg::COLS - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= cgpg_pkg::ROWS - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Drivers (all called at a falling edge, return at a falling edge)
    // ---------------------------------------------------------------

    task automatic send_pixel(bit restart);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(cgpg_pkg::S_TDATA_W-1){1'b0}}, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pixels.push_back(next_pixel(restart));
        pixels_sent++;
        if (restart)
            restarts_sent++;
        @(negedge i_clk);
    endtask

    // leaves i_cfg_valid high so writes can go back to back
    task automatic write_corner(cgpg_pkg::t_cfg_idx idx, logic [23:0] rgb);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= rgb;
        do @(posedge i_clk); while (!o_cfg_ready);
        corner_rgb[idx] = rgb;
        corner_writes++;
        @(negedge i_clk);
    endtask

    task automatic program_corners(logic [23:0] tl, logic [23:0] tr,
                                   logic [23:0] bl, logic [23:0] br);
        write_corner(cgpg_pkg::CFG_TOP_LEFT, tl);
        write_corner(cgpg_pkg::CFG_TOP_RIGHT, tr);
        write_corner(cgpg_pkg::CFG_BOTTOM_LEFT, bl);
        write_corner(cgpg_pkg::CFG_BOTTOM_RIGHT, br);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every pixel in flight has come back
    task automatic wait_results;
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_pixels.size() != 0);
    endtask

    // idle the block fully before touching the corners
    task automatic drain_block;
        wait_results();
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_pixels(int count, int restart_one_in, bit pause_midway);
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2)
                wait_results();
            send_pixel(restart_one_in > 0 && $urandom_range(1, restart_one_in) == 1);
        end
    endtask

    // each channel is either 00 or FF
    function automatic logic [23:0] extreme_rgb();
        logic [23:0] v;
        for (int c = 0; c < 3; c++)
            v[c*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return v;
    endfunction

    function automatic logic [23:0] random_rgb();
        return 24'($urandom);
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random back-pressure on the output stream
    // ---------------------------------------------------------------
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Checker: every output word against the oldest expected pixel
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_w.red       = m_axis_tdata[7:0];
            got_w.green     = m_axis_tdata[15:8];
            got_w.blue      = m_axis_tdata[23:16];
            got_w.row       = m_axis_tdata[33:24];
            got_w.col       = m_axis_tdata[43:34];
            got_w.frame_end = m_axis_tlast;
            if (m_axis_tlast)
                frame_ends_seen++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: output word with no pixel pending: %h last=%b",
                             $realtime, m_axis_tdata, m_axis_tlast);
            end else begin
                want_w = expected_pixels.pop_front();
                if (got_w.red !== want_w.red || got_w.green !== want_w.green ||
                    got_w.blue !== want_w.blue || got_w.row !== want_w.row ||
                    got_w.col !== want_w.col || got_w.frame_end !== want_w.frame_end ||
                    m_axis_tdata[47:44] !== 4'h0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("%0t: pixel %0d expected r=%h g=%h b=%h row=%0d col=%0d end=%b",
                                 $realtime, pixels_checked,
                                 want_w.red, want_w.green, want_w.blue,
                                 want_w.row, want_w.col, want_w.frame_end);
                        $display("    got r=%h g=%h b=%h row=%0d col=%0d end=%b pad=%h",
                                 got_w.red, got_w.green, got_w.blue,
                                 got_w.row, got_w.col, got_w.frame_end,
                                 m_axis_tdata[47:44]);
                    end
                end
            end
            pixels_checked++;
        end
    end

    // watchdog: nothing moving on any channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // corners still at reset: every pixel black, position counts from 0
    task automatic test_reset_corners;
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        drain_block();
    endtask

    // full-scale and zero corners, restart in the middle of a row
    task automatic test_extreme_corners;
        program_corners(24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00);
        send_pixel(1'b1);
        repeat (4) send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        drain_block();
        program_corners(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(1'b1);
        repeat (2) send_pixel(1'b0);
        drain_block();
    endtask

    // new corners mid-row must not disturb the rest of the row
    task automatic test_mid_row_corner_change;
        program_corners(random_rgb(), random_rgb(), random_rgb(), random_rgb());
        send_pixel(1'b1);
        repeat (3) send_pixel(1'b0);
        drain_block();
        program_corners(random_rgb(), random_rgb(), random_rgb(), random_rgb());
        repeat (4) send_pixel(1'b0);
        drain_block();
    endtask

    // long runs across rows, rare restarts, varied corners and idling
    task automatic test_random_rows;
        int style;
        for (int phase = 0; phase < 8; phase++) begin
            style = $urandom_range(0, 3);
            case (style)
                0: program_corners(random_rgb(), random_rgb(), random_rgb(), random_rgb());
                1: program_corners(24'h000000, 24'h000000, 24'h000000, 24'h000000);
                2: program_corners(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                default: program_corners(extreme_rgb(), extreme_rgb(),
                                         extreme_rgb(), extreme_rgb());
            endcase
            // some phases run with one or both sides at full speed
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            run_pixels(150, 400, (phase % 3) == 1);
            drain_block();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // one whole row and a bit at full rate: last column and wrap to the next row
    task automatic test_full_rate;
        program_corners(random_rgb(), random_rgb(), random_rgb(), random_rgb());
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_pixel(1'b1);
        run_pixels(ROW_PIXELS + 12, 0, 1'b0);
        drain_block();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = cgpg_pkg::CFG_TOP_LEFT;
        i_cfg_data    = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        mismatches      = 0;
        pixels_sent     = 0;
        pixels_checked  = 0;
        frame_ends_seen = 0;
        restarts_sent   = 0;
        corner_writes   = 0;
        quiet_cycles    = 0;
        row_pos = 0;
        col_pos = 0;
        for (int c = 0; c < 3; c++) begin
            left_edge[c]  = 0;
            right_edge[c] = 0;
        end
        corner_rgb[cgpg_pkg::CFG_TOP_LEFT]     = '0;
        corner_rgb[cgpg_pkg::CFG_TOP_RIGHT]    = '0;
        corner_rgb[cgpg_pkg::CFG_BOTTOM_LEFT]  = '0;
        corner_rgb[cgpg_pkg::CFG_BOTTOM_RIGHT] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_corners();
        test_extreme_corners();
        test_mid_row_corner_change();
        test_random_rows();
        test_full_rate();
        drain_block();

        $display("Checked %0d pixels (%0d restarts, %0d frame ends) over %0d corner writes,",
                 pixels_checked, restarts_sent, frame_ends_seen, corner_writes);
        $display("with random input gaps and output stalls plus one full-rate row crossing.");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatching pixels", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cgpg_pkg.sv
rtl/cgpg_front.sv
rtl/cgpg_fifo.sv
rtl/cgpg_back.sv
rtl/corner_gradient_pixel_generator.sv
tb/tb_corner_gradient_pixel_generator.sv
